/* design/crls_pkg.sv */
// Shared types, constants and the permutation table of the Cramer's-rule solver.
// Used by crls_ctrl, crls_dp and cramer_rule_linear_solver; depends on nothing.
package crls_pkg;

   localparam int MAX_ORDER  = 4;
   localparam int IDXW       = 2;
   localparam int VALW       = 32;
   localparam int PRODW      = VALW * MAX_ORDER;
   localparam int ACCW       = PRODW + 4;
   localparam int MAGW       = ACCW;
   localparam int FRACW      = 16;
   localparam int DVDW       = MAGW + FRACW;
   localparam int SOLW       = 48;
   localparam int QW         = SOLW + 1;
   localparam int PERMS      = 24;
   localparam int PERMW      = 5;
   localparam int DIV_STEPS  = DVDW;
   localparam int DIVCW      = 8;
   localparam int ORDW       = 3;

   localparam logic [PERMW-1:0] PERM_LAST  = PERMW'(PERMS - 1);
   localparam logic [DIVCW-1:0] DIV_LAST   = DIVCW'(DIV_STEPS - 1);
   localparam logic [QW-1:0]    SOL_NEG_MAG = QW'(1) << (SOLW - 1);
   localparam logic [QW-1:0]    SOL_POS_MAX = SOL_NEG_MAG - QW'(1);

   localparam logic [1:0] ACT_LOAD_COEF = 2'd0;
   localparam logic [1:0] ACT_LOAD_RHS  = 2'd1;
   localparam logic [1:0] ACT_SOLVE     = 2'd2;

   // Permutations of four columns in lexicographic order, column of row i in bits 2i+1:2i.
   localparam logic [7:0] PERM_TABLE [PERMS] = '{
      8'd228, 8'd180, 8'd216, 8'd120, 8'd156, 8'd108,
      8'd225, 8'd177, 8'd201, 8'd57,  8'd141, 8'd45,
      8'd210, 8'd114, 8'd198, 8'd54,  8'd78,  8'd30,
      8'd147, 8'd99,  8'd135, 8'd39,  8'd75,  8'd27
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_DETINIT, ST_TERM, ST_FETCH, ST_MUL, ST_ACC, ST_DETDONE,
      ST_DIVINIT, ST_DIV, ST_SETOUT, ST_EMIT
   } state_type;

   typedef struct packed {
      logic             clear_acc;
      logic             fetch;
      logic             mul;
      logic             acc;
      logic             save_den;
      logic             div_init;
      logic             div_step;
      logic             set_out;
      logic             kactive;
      logic [IDXW-1:0]  row;
      logic [IDXW-1:0]  limb;
      logic [IDXW-1:0]  k;
      logic [PERMW-1:0] perm;
      logic             rd_kactive;
      logic [IDXW-1:0]  rd_row;
      logic [IDXW-1:0]  rd_k;
      logic [PERMW-1:0] rd_perm;
   } cmd_type;

   typedef struct packed {
      logic acc_zero;
      logic singular;
   } status_type;

   function automatic logic [IDXW-1:0] perm_col(logic [PERMW-1:0] idx, logic [IDXW-1:0] r);
      logic [7:0] ent;
      ent = PERM_TABLE[idx];
      return ent[{r, 1'b0} +: IDXW];
   endfunction

   function automatic logic perm_odd(logic [PERMW-1:0] idx);
      return idx[0] ^ idx[1];
   endfunction

   // A term belongs to an order-n expansion when rows n and up keep their own column.
   function automatic logic perm_fits(logic [PERMW-1:0] idx, logic [IDXW-1:0] nm1);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < MAX_ORDER; i++) begin
         if (IDXW'(i) > nm1 && perm_col(idx, IDXW'(i)) != IDXW'(i)) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

/* design/crls_ctrl.sv */
// Sequencer of the solver: walks determinant terms, limb products and the divider.
// Depends on crls_pkg; drives crls_dp through a command struct.
module crls_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_accept,
   input  logic [1:0]                 req_action,
   input  logic [crls_pkg::IDXW-1:0]  nm1,
   input  crls_pkg::status_type       status,
   output crls_pkg::cmd_type          cmd,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready
);

   crls_pkg::state_type          state_ff, state_in;
   logic [crls_pkg::IDXW-1:0]    row_ff, row_in;
   logic [crls_pkg::IDXW-1:0]    limb_ff, limb_in;
   logic [crls_pkg::IDXW-1:0]    k_ff, k_in;
   logic [crls_pkg::PERMW-1:0]   perm_ff, perm_in;
   logic [crls_pkg::DIVCW-1:0]   div_ff, div_in;
   logic                         kact_ff, kact_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crls_pkg::ST_IDLE;
         row_ff   <= '0;
         limb_ff  <= '0;
         k_ff     <= '0;
         perm_ff  <= '0;
         div_ff   <= '0;
         kact_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         limb_ff  <= limb_in;
         k_ff     <= k_in;
         perm_ff  <= perm_in;
         div_ff   <= div_in;
         kact_ff  <= kact_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      limb_in  = limb_ff;
      k_in     = k_ff;
      perm_in  = perm_ff;
      div_in   = div_ff;
      kact_in  = kact_ff;
      case (state_ff)
         crls_pkg::ST_IDLE: begin
            if (req_accept && req_action == crls_pkg::ACT_SOLVE) begin
               kact_in  = 1'b0;
               k_in     = '0;
               state_in = crls_pkg::ST_DETINIT;
            end
         end
         crls_pkg::ST_DETINIT: begin
            perm_in  = '0;
            state_in = crls_pkg::ST_TERM;
         end
         crls_pkg::ST_TERM: begin
            if (crls_pkg::perm_fits(perm_ff, nm1)) begin
               row_in   = '0;
               state_in = crls_pkg::ST_FETCH;
            end else if (perm_ff == crls_pkg::PERM_LAST) begin
               state_in = crls_pkg::ST_DETDONE;
            end else begin
               perm_in = perm_ff + 1'b1;
            end
         end
         crls_pkg::ST_FETCH: begin
            if (row_ff == '0) begin
               if (nm1 == '0) begin
                  state_in = crls_pkg::ST_ACC;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               limb_in  = '0;
               state_in = crls_pkg::ST_MUL;
            end
         end
         crls_pkg::ST_MUL: begin
            limb_in = limb_ff + 1'b1;
            if (limb_ff == '1) begin
               if (row_ff == nm1) begin
                  state_in = crls_pkg::ST_ACC;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = crls_pkg::ST_FETCH;
               end
            end
         end
         crls_pkg::ST_ACC: begin
            if (perm_ff == crls_pkg::PERM_LAST) begin
               state_in = crls_pkg::ST_DETDONE;
            end else begin
               perm_in  = perm_ff + 1'b1;
               state_in = crls_pkg::ST_TERM;
            end
         end
         crls_pkg::ST_DETDONE: begin
            if (kact_ff) begin
               state_in = crls_pkg::ST_DIVINIT;
            end else if (status.acc_zero) begin
               state_in = crls_pkg::ST_SETOUT;
            end else begin
               kact_in  = 1'b1;
               state_in = crls_pkg::ST_DETINIT;
            end
         end
         crls_pkg::ST_DIVINIT: begin
            div_in   = '0;
            state_in = crls_pkg::ST_DIV;
         end
         crls_pkg::ST_DIV: begin
            div_in = div_ff + 1'b1;
            if (div_ff == crls_pkg::DIV_LAST) begin
               state_in = crls_pkg::ST_SETOUT;
            end
         end
         crls_pkg::ST_SETOUT: begin
            state_in = crls_pkg::ST_EMIT;
         end
         crls_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               if (k_ff == nm1) begin
                  state_in = crls_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = status.singular ? crls_pkg::ST_SETOUT : crls_pkg::ST_DETINIT;
               end
            end
         end
         default: state_in = crls_pkg::ST_IDLE;
      endcase
   end

   // The store read address is taken from the next-state values so that the element is registered at fetch.
   always_comb begin
      cmd            = '0;
      cmd.row        = row_ff;
      cmd.limb       = limb_ff;
      cmd.k          = k_ff;
      cmd.perm       = perm_ff;
      cmd.kactive    = kact_ff;
      cmd.rd_row     = row_in;
      cmd.rd_k       = k_in;
      cmd.rd_perm    = perm_in;
      cmd.rd_kactive = kact_in;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      case (state_ff)
         crls_pkg::ST_IDLE:    req_ready     = 1'b1;
         crls_pkg::ST_DETINIT: cmd.clear_acc = 1'b1;
         crls_pkg::ST_FETCH:   cmd.fetch     = 1'b1;
         crls_pkg::ST_MUL:     cmd.mul       = 1'b1;
         crls_pkg::ST_ACC:     cmd.acc       = 1'b1;
         crls_pkg::ST_DETDONE: cmd.save_den  = !kact_ff;
         crls_pkg::ST_DIVINIT: cmd.div_init  = 1'b1;
         crls_pkg::ST_DIV:     cmd.div_step  = 1'b1;
         crls_pkg::ST_SETOUT:  cmd.set_out   = 1'b1;
         crls_pkg::ST_EMIT:    rsp_valid     = 1'b1;
         default:              req_ready     = 1'b0;
      endcase
   end

`ifndef SYNTHESIS
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result side open together");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == crls_pkg::ST_EMIT && !rsp_ready |=> state_ff == crls_pkg::ST_EMIT)
      else $error("result word dropped while stalled");
   a_acc_rows: assert property (@(posedge clock) disable iff (reset)
      state_ff == crls_pkg::ST_ACC |-> row_ff == nm1)
      else $error("term accumulated before all rows were multiplied");
`endif

endmodule

/* design/crls_dp.sv */
// Datapath of the solver: coefficient and right-hand-side stores, limb multiplier,
// determinant accumulator, restoring divider and result registers. Depends on crls_pkg.
module crls_dp (
   input  logic                       clock,
   input  logic                       req_accept,
   input  logic [1:0]                 req_action,
   input  logic [crls_pkg::IDXW-1:0]  req_row,
   input  logic [crls_pkg::IDXW-1:0]  req_column,
   input  logic [crls_pkg::VALW-1:0]  req_value,
   input  logic [crls_pkg::IDXW-1:0]  nm1,
   input  crls_pkg::cmd_type          cmd,
   output crls_pkg::status_type       status,
   output logic [crls_pkg::IDXW-1:0]  out_index,
   output logic [crls_pkg::SOLW-1:0]  out_solution,
   output logic                       out_singular,
   output logic                       out_last
);

   logic [crls_pkg::VALW-1:0]  coef_mem [crls_pkg::MAX_ORDER*crls_pkg::MAX_ORDER];
   logic [crls_pkg::VALW-1:0]  rhs_mem  [crls_pkg::MAX_ORDER];

   logic [crls_pkg::VALW-1:0]  elem_ff;
   logic [crls_pkg::PRODW-1:0] prod_ff;
   logic [crls_pkg::VALW-1:0]  mul_ff;
   logic [crls_pkg::VALW-1:0]  carry_ff;
   logic                       sign_ff;
   logic [crls_pkg::ACCW-1:0]  acc_ff;
   logic [crls_pkg::MAGW-1:0]  den_ff;
   logic                       den_neg_ff;
   logic                       sing_ff;
   logic [crls_pkg::DVDW-1:0]  dvd_ff;
   logic [crls_pkg::MAGW-1:0]  rem_ff;
   logic [crls_pkg::QW-1:0]    q_ff;
   logic                       over_ff;
   logic                       neg_ff;
   logic [crls_pkg::IDXW-1:0]  out_index_ff;
   logic [crls_pkg::SOLW-1:0]  out_sol_ff;
   logic                       out_sing_ff;
   logic                       out_last_ff;

   logic [crls_pkg::IDXW-1:0]  rd_col;
   logic [crls_pkg::VALW-1:0]  elem_mag;
   logic [2*crls_pkg::VALW-1:0] limb_prod;
   logic [crls_pkg::ACCW-1:0]  term;
   logic [crls_pkg::MAGW-1:0]  acc_mag;
   logic [crls_pkg::MAGW:0]    rem_sh;
   logic [crls_pkg::MAGW:0]    rem_diff;
   logic                       q_bit;
   logic [crls_pkg::QW-1:0]    q_next;
   logic [crls_pkg::QW-1:0]    q_sat;
   logic [crls_pkg::SOLW-1:0]  sol_val;

   always_ff @(posedge clock) begin
      if (req_accept && req_action == crls_pkg::ACT_LOAD_COEF) begin
         coef_mem[{req_row, req_column}] <= req_value;
      end
      if (req_accept && req_action == crls_pkg::ACT_LOAD_RHS) begin
         rhs_mem[req_row] <= req_value;
      end
      elem_ff <= (cmd.rd_kactive && rd_col == cmd.rd_k) ? rhs_mem[cmd.rd_row]
                                                       : coef_mem[{cmd.rd_row, rd_col}];
   end

   always_comb begin
      rd_col    = crls_pkg::perm_col(cmd.rd_perm, cmd.rd_row);
      elem_mag  = elem_ff[crls_pkg::VALW-1] ? (~elem_ff + 1'b1) : elem_ff;
      limb_prod = prod_ff[cmd.limb*crls_pkg::VALW +: crls_pkg::VALW] * mul_ff
                  + {{crls_pkg::VALW{1'b0}}, (cmd.limb == '0) ? '0 : carry_ff};
      term      = {{(crls_pkg::ACCW-crls_pkg::PRODW){1'b0}}, prod_ff};
      acc_mag   = acc_ff[crls_pkg::ACCW-1] ? (~acc_ff + 1'b1) : acc_ff;
      rem_sh    = {rem_ff, dvd_ff[crls_pkg::DVDW-1]};
      rem_diff  = rem_sh - {1'b0, den_ff};
      q_bit     = !rem_diff[crls_pkg::MAGW];
      q_next    = {q_ff[crls_pkg::QW-2:0], q_bit};
      if (neg_ff) begin
         q_sat   = over_ff ? crls_pkg::SOL_NEG_MAG : q_ff;
         sol_val = crls_pkg::SOLW'(~q_sat + 1'b1);
      end else begin
         q_sat   = (over_ff || q_ff > crls_pkg::SOL_POS_MAX) ? crls_pkg::SOL_POS_MAX : q_ff;
         sol_val = q_sat[crls_pkg::SOLW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         acc_ff <= '0;
      end else if (cmd.acc) begin
         acc_ff <= sign_ff ? acc_ff - term : acc_ff + term;
      end
      if (cmd.fetch) begin
         if (cmd.row == '0) begin
            prod_ff <= {{(crls_pkg::PRODW-crls_pkg::VALW){1'b0}}, elem_mag};
            sign_ff <= elem_ff[crls_pkg::VALW-1] ^ crls_pkg::perm_odd(cmd.perm);
         end else begin
            mul_ff  <= elem_mag;
            sign_ff <= sign_ff ^ elem_ff[crls_pkg::VALW-1];
         end
      end
      if (cmd.mul) begin
         prod_ff[cmd.limb*crls_pkg::VALW +: crls_pkg::VALW] <= limb_prod[crls_pkg::VALW-1:0];
         carry_ff <= limb_prod[2*crls_pkg::VALW-1:crls_pkg::VALW];
      end
      if (cmd.save_den) begin
         den_ff     <= acc_mag;
         den_neg_ff <= acc_ff[crls_pkg::ACCW-1];
         sing_ff    <= (acc_ff == '0);
      end
      if (cmd.div_init) begin
         dvd_ff  <= {acc_mag, {crls_pkg::FRACW{1'b0}}};
         neg_ff  <= acc_ff[crls_pkg::ACCW-1] ^ den_neg_ff;
         rem_ff  <= '0;
         q_ff    <= '0;
         over_ff <= 1'b0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[crls_pkg::DVDW-2:0], 1'b0};
         rem_ff <= q_bit ? rem_diff[crls_pkg::MAGW-1:0] : rem_sh[crls_pkg::MAGW-1:0];
         if (!over_ff) begin
            q_ff <= q_next;
            if (q_next > crls_pkg::SOL_NEG_MAG) begin
               over_ff <= 1'b1;
            end
         end
      end
      if (cmd.set_out) begin
         out_index_ff <= cmd.k;
         out_sol_ff   <= sing_ff ? '0 : sol_val;
         out_sing_ff  <= sing_ff;
         out_last_ff  <= (cmd.k == nm1);
      end
   end

   assign status.acc_zero = (acc_ff == '0);
   assign status.singular = sing_ff;
   assign out_index       = out_index_ff;
   assign out_solution    = out_sol_ff;
   assign out_singular    = out_sing_ff;
   assign out_last        = out_last_ff;

endmodule

/* design/cramer_rule_linear_solver.sv */
// Cramer's-rule solver for systems of order 1 to 4. A solve of order n walks all 24 column
// permutations for the denominator and, if it is non-zero, for each of the n numerator
// determinants: a skipped permutation needs only the term check, a used one takes the
// term check, n element fetches, 4(n-1) limb products on the single 32x32 multiplier
// and one accumulate, and each unknown then goes through the bit-serial divider.
// Results leave one word per unknown; a singular system skips the numerators.
// Depends on crls_pkg, crls_ctrl and crls_dp.
module cramer_rule_linear_solver (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata,     // matrix_size
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,     // action[1:0], row[3:2], column[5:4], value[37:6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,     // unknown_index[1:0], solution[49:2]
   output logic        rsp_tuser,     // singular
   output logic        rsp_tlast
);

   logic [crls_pkg::ORDW-1:0] order_ff, order_in;
   logic [crls_pkg::IDXW-1:0] nm1;
   logic                      req_accept;
   crls_pkg::cmd_type         cmd;
   crls_pkg::status_type      status;
   logic [crls_pkg::IDXW-1:0] out_index;
   logic [crls_pkg::SOLW-1:0] out_solution;

   always_comb begin
      order_in = order_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            order_in = crls_pkg::ORDW'(1);
         end else if (csr_wdata > crls_pkg::ORDW'(crls_pkg::MAX_ORDER)) begin
            order_in = crls_pkg::ORDW'(crls_pkg::MAX_ORDER);
         end else begin
            order_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= crls_pkg::ORDW'(crls_pkg::MAX_ORDER);
      end else begin
         order_ff <= order_in;
      end
   end

   assign nm1        = crls_pkg::IDXW'(order_ff - 1'b1);
   assign req_accept = req_tvalid && req_tready;

   crls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_action (req_tdata[1:0]),
      .nm1        (nm1),
      .status     (status),
      .cmd        (cmd),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready)
   );

   crls_dp u_dp (
      .clock        (clock),
      .req_accept   (req_accept),
      .req_action   (req_tdata[1:0]),
      .req_row      (req_tdata[3:2]),
      .req_column   (req_tdata[5:4]),
      .req_value    (req_tdata[37:6]),
      .nm1          (nm1),
      .cmd          (cmd),
      .status       (status),
      .out_index    (out_index),
      .out_solution (out_solution),
      .out_singular (rsp_tuser),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {6'b0, out_solution, out_index};

endmodule
